// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define LDPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define LDPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/ldpm_pkg.sv =====
// Types, constants and fixed-point helpers for the lens distortion point map
`timescale 1ns / 1ps
`default_nettype none
package ldpm_pkg;

    localparam int COEF_FRAC_BITS = 28;
    localparam int PT_W      = 21;
    localparam int FOC_W     = 24;
    localparam int OUT_W     = 24;
    localparam int IW        = 32;
    localparam int QB        = IW + 1;
    localparam int NUM_W     = PT_W + COEF_FRAC_BITS + 1;
    localparam int MQ_W      = 2 * IW - COEF_FRAC_BITS;
    localparam int WIDE_W    = 40;
    localparam int DIV_LAT   = QB + 1;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X    = 4'd0,
        CFG_FOCAL_Y    = 4'd1,
        CFG_CENTER_X   = 4'd2,
        CFG_CENTER_Y   = 4'd3,
        CFG_RADIAL_K1  = 4'd4,
        CFG_RADIAL_K2  = 4'd5,
        CFG_RADIAL_K3  = 4'd6,
        CFG_TANGENTIAL = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [PT_W-1:0] point_x;
        logic [PT_W-1:0] point_y;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] mapped_x;
        logic signed [OUT_W-1:0] mapped_y;
        logic                    saturated;
    } t_out_word;

    typedef struct packed {
        logic [FOC_W-1:0]     focal_x;
        logic [FOC_W-1:0]     focal_y;
        logic [PT_W-1:0]      center_x;
        logic [PT_W-1:0]      center_y;
        logic signed [IW-1:0] k1;
        logic signed [IW-1:0] k2;
        logic signed [IW-1:0] k3;
        logic signed [IW-1:0] p1;
        logic signed [IW-1:0] p2;
    } t_cfg;

    localparam logic signed [WIDE_W-1:0] I32_MAX =
        $signed({{(WIDE_W-IW+1){1'b0}}, {(IW-1){1'b1}}});
    localparam logic signed [WIDE_W-1:0] I32_MIN =
        $signed({{(WIDE_W-IW+1){1'b1}}, {(IW-1){1'b0}}});
    localparam logic signed [WIDE_W-1:0] O24_MAX =
        $signed({{(WIDE_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
    localparam logic signed [WIDE_W-1:0] O24_MIN =
        $signed({{(WIDE_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}});

    // product rounded half up back to COEF_FRAC_BITS fraction bits
    function automatic logic signed [MQ_W-1:0] mulq(input logic signed [IW-1:0] a,
                                                    input logic signed [IW-1:0] b);
        logic signed [2*IW-1:0] p;
        p = a * b;
        p = p + $signed({{(2*IW-COEF_FRAC_BITS){1'b0}}, 1'b1,
                         {(COEF_FRAC_BITS-1){1'b0}}});
        return p[2*IW-1:COEF_FRAC_BITS];
    endfunction

    function automatic logic signed [IW-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = (v > I32_MAX) ? I32_MAX : ((v < I32_MIN) ? I32_MIN : v);
        return c[IW-1:0];
    endfunction

    function automatic logic ovf32(input logic signed [WIDE_W-1:0] v);
        return (v > I32_MAX) || (v < I32_MIN);
    endfunction

    function automatic logic signed [OUT_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = (v > O24_MAX) ? O24_MAX : ((v < O24_MIN) ? O24_MIN : v);
        return c[OUT_W-1:0];
    endfunction

    function automatic logic ovf24(input logic signed [WIDE_W-1:0] v);
        return (v > O24_MAX) || (v < O24_MIN);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ldpm_div.sv =====
// Pipelined restoring divider: an entry stage, then one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
`default_nettype none
module ldpm_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [ldpm_pkg::NUM_W-1:0] i_num,
    input  logic [ldpm_pkg::FOC_W-1:0] i_den,
    input  logic                       i_neg,
    output logic [ldpm_pkg::QB-1:0]    o_quot,
    output logic                       o_ovf,
    output logic                       o_neg
);
    import ldpm_pkg::*;

    logic [FOC_W-1:0] r_rem [0:QB-1];
    logic [QB-1:0]    r_lo  [0:QB-1];
    logic [QB-1:0]    r_q   [0:QB];
    logic             r_ovf [0:QB];
    logic             r_neg [0:QB];
    logic [NUM_W-1:0] hi;

    assign hi = i_num >> QB;

    // entry: quotient of 2^QB or more can only saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= hi[FOC_W-1:0];
            r_lo[0]  <= i_num[QB-1:0];
            r_q[0]   <= '0;
            r_ovf[0] <= (hi >= NUM_W'(i_den));
            r_neg[0] <= i_neg;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [FOC_W:0] t;
        logic [FOC_W:0] d;
        logic           ge;
        assign t  = {r_rem[k], r_lo[k][QB-1]};
        assign ge = (t >= {1'b0, i_den});
        assign d  = t - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1]   <= {r_q[k][QB-2:0], ge};
                r_ovf[k+1] <= r_ovf[k];
                r_neg[k+1] <= r_neg[k];
            end
        end

        if (k < QB - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= ge ? d[FOC_W-1:0] : t[FOC_W-1:0];
                    r_lo[k+1]  <= r_lo[k] << 1;
                end
            end
        end
    end

    assign o_quot = r_q[QB];
    assign o_ovf  = r_ovf[QB];
    assign o_neg  = r_neg[QB];

endmodule
`default_nettype wire

// ===== hdl/ldpm_cfg.sv =====
// Configuration register file for the lens distortion point map
`timescale 1ns / 1ps
`default_nettype none
module ldpm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [ldpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ldpm_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output ldpm_pkg::t_cfg                 o_cfg
);
    import ldpm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x  <= FOC_W'(131072);
            r_cfg.focal_y  <= FOC_W'(131072);
            r_cfg.center_x <= PT_W'(81920);
            r_cfg.center_y <= PT_W'(61440);
            r_cfg.k1       <= '0;
            r_cfg.k2       <= '0;
            r_cfg.k3       <= '0;
            r_cfg.p1       <= '0;
            r_cfg.p2       <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL_X:    r_cfg.focal_x  <= i_cfg_data[FOC_W-1:0];
                CFG_FOCAL_Y:    r_cfg.focal_y  <= i_cfg_data[FOC_W-1:0];
                CFG_CENTER_X:   r_cfg.center_x <= i_cfg_data[PT_W-1:0];
                CFG_CENTER_Y:   r_cfg.center_y <= i_cfg_data[PT_W-1:0];
                CFG_RADIAL_K1:  r_cfg.k1       <= $signed(i_cfg_data[IW-1:0]);
                CFG_RADIAL_K2:  r_cfg.k2       <= $signed(i_cfg_data[IW-1:0]);
                CFG_RADIAL_K3:  r_cfg.k3       <= $signed(i_cfg_data[IW-1:0]);
                CFG_TANGENTIAL: begin
                    r_cfg.p1 <= $signed(i_cfg_data[IW-1:0]);
                    r_cfg.p2 <= $signed(i_cfg_data[2*IW-1:IW]);
                end
                default: ; // unknown index: ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== hdl/lens_distortion_point_map_unit.sv =====
// Top level: Brown-Conrady lens distortion of one pixel coordinate per word
//
//  channel | direction | handshake                 | payload
//  in      | to block  | i_in_valid / o_in_ready   | i_in_word  (point_x, point_y)
//  out     | from block| o_out_valid / i_out_ready | o_out_word (mapped_x, mapped_y, saturated)
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word per cycle unless the output stalls. Stages: one prep stage, 34 divider
// stages (an entry stage, then one quotient bit each) and 11 multiply/add stages.
// The whole pipeline holds while the output word waits; o_in_ready drops then.
// Reset clears the valid bits and loads the configuration reset values.
// Config writes are always taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lens_distortion_point_map_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ldpm_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ldpm_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ldpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ldpm_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import ldpm_pkg::*;

    localparam int LAT = DIV_LAT + 12;
    typedef logic signed [IW-1:0]     t_q;
    typedef logic signed [MQ_W-1:0]   t_m;
    typedef logic signed [WIDE_W-1:0] t_w;

    t_cfg cfg;
    logic en;
    logic [LAT-1:0] r_vld;

    ldpm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );
    assign o_cfg_ready = 1'b1;

    assign en         = !(r_vld[LAT-1] && !i_out_ready);
    assign o_in_ready = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // ---- prep: centred magnitude scaled up, plus half divisor for rounding
    logic [FOC_W-1:0]  den_x, den_y;
    logic signed [PT_W:0] dif_x, dif_y;
    logic [PT_W:0]     abs_x, abs_y;
    logic [NUM_W-1:0]  r0_num_x, r0_num_y;
    logic              r0_neg_x, r0_neg_y;

    assign den_x = (cfg.focal_x == '0) ? FOC_W'(1) : cfg.focal_x;
    assign den_y = (cfg.focal_y == '0) ? FOC_W'(1) : cfg.focal_y;
    assign dif_x = $signed({1'b0, i_in_word.point_x}) - $signed({1'b0, cfg.center_x});
    assign dif_y = $signed({1'b0, i_in_word.point_y}) - $signed({1'b0, cfg.center_y});
    assign abs_x = dif_x[PT_W] ? -dif_x : dif_x;
    assign abs_y = dif_y[PT_W] ? -dif_y : dif_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_num_x <= NUM_W'({abs_x[PT_W-1:0], {COEF_FRAC_BITS{1'b0}}})
                        + NUM_W'(den_x >> 1);
            r0_num_y <= NUM_W'({abs_y[PT_W-1:0], {COEF_FRAC_BITS{1'b0}}})
                        + NUM_W'(den_y >> 1);
            r0_neg_x <= dif_x[PT_W];
            r0_neg_y <= dif_y[PT_W];
        end
    end

    logic [QB-1:0] q_x, q_y;
    logic ov_x, ov_y, ng_x, ng_y;

    ldpm_div u_div_x (
        .i_clk (i_clk), .i_en (en), .i_num (r0_num_x), .i_den (den_x),
        .i_neg (r0_neg_x), .o_quot (q_x), .o_ovf (ov_x), .o_neg (ng_x)
    );
    ldpm_div u_div_y (
        .i_clk (i_clk), .i_en (en), .i_num (r0_num_y), .i_den (den_y),
        .i_neg (r0_neg_y), .o_quot (q_y), .o_ovf (ov_y), .o_neg (ng_y)
    );

    // ---- S1: signed normalised coordinates
    t_w sq_x, sq_y;
    assign sq_x = ng_x ? -t_w'({1'b0, q_x}) : t_w'({1'b0, q_x});
    assign sq_y = ng_y ? -t_w'({1'b0, q_y}) : t_w'({1'b0, q_y});

    t_q r1_x1, r1_y1;
    logic r1_f;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x1 <= ov_x ? (ng_x ? sat32(I32_MIN) : sat32(I32_MAX)) : sat32(sq_x);
            r1_y1 <= ov_y ? (ng_y ? sat32(I32_MIN) : sat32(I32_MAX)) : sat32(sq_y);
            r1_f  <= ov_x || ov_y || ovf32(sq_x) || ovf32(sq_y);
        end
    end

    // ---- S2: squares and cross term
    t_w m_xx, m_yy, m_xy;
    assign m_xx = t_w'(mulq(r1_x1, r1_x1));
    assign m_yy = t_w'(mulq(r1_y1, r1_y1));
    assign m_xy = t_w'(mulq(r1_x1, r1_y1));

    t_q r2_x1, r2_y1, r2_xx, r2_yy, r2_xy;
    logic r2_f;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x1 <= r1_x1;
            r2_y1 <= r1_y1;
            r2_xx <= sat32(m_xx);
            r2_yy <= sat32(m_yy);
            r2_xy <= sat32(m_xy);
            r2_f  <= r1_f || ovf32(m_xx) || ovf32(m_yy) || ovf32(m_xy);
        end
    end

    // ---- S3: r^2
    t_w s_r2;
    assign s_r2 = t_w'(r2_xx) + t_w'(r2_yy);

    t_q r3_x1, r3_y1, r3_xx, r3_yy, r3_xy, r3_r2;
    logic r3_f;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_x1 <= r2_x1;
            r3_y1 <= r2_y1;
            r3_xx <= r2_xx;
            r3_yy <= r2_yy;
            r3_xy <= r2_xy;
            r3_r2 <= sat32(s_r2);
            r3_f  <= r2_f || ovf32(s_r2);
        end
    end

    // ---- S4: r^4, tangential sums, k1 term
    t_w m_r4, s_tx, s_ty;
    assign m_r4 = t_w'(mulq(r3_r2, r3_r2));
    assign s_tx = t_w'(r3_r2) + t_w'(r3_xx) + t_w'(r3_xx);
    assign s_ty = t_w'(r3_r2) + t_w'(r3_yy) + t_w'(r3_yy);

    t_q r4_x1, r4_y1, r4_xy, r4_r2, r4_r4, r4_tx, r4_ty;
    t_m r4_kr2;
    logic r4_f;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_x1  <= r3_x1;
            r4_y1  <= r3_y1;
            r4_xy  <= r3_xy;
            r4_r2  <= r3_r2;
            r4_r4  <= sat32(m_r4);
            r4_tx  <= sat32(s_tx);
            r4_ty  <= sat32(s_ty);
            r4_kr2 <= mulq(cfg.k1, r3_r2);
            r4_f   <= r3_f || ovf32(m_r4) || ovf32(s_tx) || ovf32(s_ty);
        end
    end

    // ---- S5: r^6, k2 term
    t_w m_r6;
    assign m_r6 = t_w'(mulq(r4_r4, r4_r2));

    t_q r5_x1, r5_y1, r5_xy, r5_r6, r5_tx, r5_ty;
    t_m r5_kr2, r5_k2r4;
    logic r5_f;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_x1   <= r4_x1;
            r5_y1   <= r4_y1;
            r5_xy   <= r4_xy;
            r5_r6   <= sat32(m_r6);
            r5_tx   <= r4_tx;
            r5_ty   <= r4_ty;
            r5_kr2  <= r4_kr2;
            r5_k2r4 <= mulq(cfg.k2, r4_r4);
            r5_f    <= r4_f || ovf32(m_r6);
        end
    end

    // ---- S6: k3 term and tangential products
    t_q r6_x1, r6_y1;
    t_m r6_kr2, r6_k2r4, r6_k3r6, r6_pxy, r6_p2tx, r6_p1ty, r6_p2xy;
    logic r6_f;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_x1   <= r5_x1;
            r6_y1   <= r5_y1;
            r6_kr2  <= r5_kr2;
            r6_k2r4 <= r5_k2r4;
            r6_k3r6 <= mulq(cfg.k3, r5_r6);
            r6_pxy  <= mulq(cfg.p1, r5_xy);
            r6_p2tx <= mulq(cfg.p2, r5_tx);
            r6_p1ty <= mulq(cfg.p1, r5_ty);
            r6_p2xy <= mulq(cfg.p2, r5_xy);
            r6_f    <= r5_f;
        end
    end

    // ---- S7: radial factor
    t_w s_rad;
    assign s_rad = (t_w'(1) <<< COEF_FRAC_BITS) + t_w'(r6_kr2) + t_w'(r6_k2r4)
                   + t_w'(r6_k3r6);

    t_q r7_x1, r7_y1, r7_rad;
    t_m r7_pxy, r7_p2tx, r7_p1ty, r7_p2xy;
    logic r7_f;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_x1   <= r6_x1;
            r7_y1   <= r6_y1;
            r7_rad  <= sat32(s_rad);
            r7_pxy  <= r6_pxy;
            r7_p2tx <= r6_p2tx;
            r7_p1ty <= r6_p1ty;
            r7_p2xy <= r6_p2xy;
            r7_f    <= r6_f || ovf32(s_rad);
        end
    end

    // ---- S8: radial scaling
    t_m r8_mx, r8_my, r8_pxy, r8_p2tx, r8_p1ty, r8_p2xy;
    logic r8_f;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_mx   <= mulq(r7_x1, r7_rad);
            r8_my   <= mulq(r7_y1, r7_rad);
            r8_pxy  <= r7_pxy;
            r8_p2tx <= r7_p2tx;
            r8_p1ty <= r7_p1ty;
            r8_p2xy <= r7_p2xy;
            r8_f    <= r7_f;
        end
    end

    // ---- S9: distorted normalised point
    t_w s_x2, s_y2;
    assign s_x2 = t_w'(r8_mx) + t_w'(r8_pxy) + t_w'(r8_pxy) + t_w'(r8_p2tx);
    assign s_y2 = t_w'(r8_my) + t_w'(r8_p1ty) + t_w'(r8_p2xy) + t_w'(r8_p2xy);

    t_q r9_x2, r9_y2;
    logic r9_f;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_x2 <= sat32(s_x2);
            r9_y2 <= sat32(s_y2);
            r9_f  <= r8_f || ovf32(s_x2) || ovf32(s_y2);
        end
    end

    // ---- S10: back to pixels (focal is unsigned, zero-extended)
    t_m r10_fx, r10_fy;
    logic r10_f;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_fx <= mulq($signed(IW'(cfg.focal_x)), r9_x2);
            r10_fy <= mulq($signed(IW'(cfg.focal_y)), r9_y2);
            r10_f  <= r9_f;
        end
    end

    // ---- S11: add principal point, clip, output word register
    t_w s_mx, s_my;
    assign s_mx = t_w'(r10_fx) + t_w'({1'b0, cfg.center_x});
    assign s_my = t_w'(r10_fy) + t_w'({1'b0, cfg.center_y});

    t_out_word r11_word;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_word.mapped_x  <= sat24(s_mx);
            r11_word.mapped_y  <= sat24(s_my);
            r11_word.saturated <= r10_f || ovf24(s_mx) || ovf24(s_my);
        end
    end
    assign o_out_word = r11_word;

    // a held pipeline keeps every valid bit; a moving one shifts them
    `LDPM_ASSERT_NEXT(a_hold_vld, i_clk, i_rst_n, !en, r_vld == $past(r_vld))
    `LDPM_ASSERT_NEXT(a_shift_vld, i_clk, i_rst_n, en, r_vld[1] == $past(r_vld[0]))
    `LDPM_ASSERT_NOW(a_ready_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)

endmodule
`default_nettype wire
